/* rtl/core/mlqb_pkg.sv */
// Package: beat types and operation/status codes for the multi-linear queue buffer.
package mlqb_pkg;

  localparam int FIELD_W = 32;

  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]                op;
    logic [1:0]                queue_index;
    logic signed [FIELD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] word_out;
    logic [1:0]                status;
  } out_item_t;

endpackage

/* rtl/core/multi_linear_queue_buffer_top.sv */
// Multi-linear queue buffer: pointer update, slot store and registered result path.
// An accepted beat goes through stage s1, then out_item_r, via the skid register if out_ stalls.
// Throughput: one request per cycle unless in_stall, set by the single write and single read port.
// in_stall rises only when the skid register holds a result behind a stalled output.
// Reset clears all pointers to slot zero and marks every queue empty; the slot store is
// not cleared and needs no clearing pass.
module multi_linear_queue_buffer_top #(
  parameter int NUM_QUEUES  = 3,
  parameter int QUEUE_DEPTH = 128,
  parameter int DATA_WIDTH  = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mlqb_pkg::in_item_t in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output mlqb_pkg::out_item_t out_item
);

  localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SLOTS = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [PW-1:0]         head_r [NUM_QUEUES];
  logic [PW-1:0]         tail_r [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] empty_r;

  logic [DATA_WIDTH-1:0] mem [SLOTS];
  logic [DATA_WIDTH-1:0] rd_r;

  logic                  s1_valid_r;
  logic                  s1_hit_r;
  logic [1:0]            s1_status_r;

  logic                  out_valid_r;
  mlqb_pkg::out_item_t   out_item_r;
  logic                  sk_valid_r;
  mlqb_pkg::out_item_t   sk_item_r;

  logic                  accept;
  logic                  q_ok;
  logic [QW-1:0]         q;
  logic [PW-1:0]         cur_head;
  logic [PW-1:0]         cur_tail;
  logic                  cur_empty;
  logic [AW-1:0]         base;
  logic [AW-1:0]         raddr;
  logic [AW-1:0]         waddr;
  logic                  wen;
  logic                  hit;
  logic [1:0]            status;
  logic                  ptr_wen;
  logic [PW-1:0]         head_nxt;
  logic [PW-1:0]         tail_nxt;
  logic                  empty_nxt;
  logic                  out_free;
  logic                  s1_move;
  mlqb_pkg::out_item_t   s1_item;

  assign accept   = in_valid && !sk_valid_r;
  assign in_stall = sk_valid_r;

  assign q_ok      = (7'(in_item.queue_index) < 7'(NUM_QUEUES));
  assign q         = QW'(in_item.queue_index);
  assign cur_head  = head_r[q];
  assign cur_tail  = tail_r[q];
  assign cur_empty = empty_r[q];
  assign base      = AW'(q) * AW'(QUEUE_DEPTH);
  assign raddr     = base + AW'(cur_head);

  always_comb begin
    wen       = 1'b0;
    waddr     = base;
    hit       = 1'b0;
    status    = mlqb_pkg::ST_DONE;
    ptr_wen   = 1'b0;
    head_nxt  = cur_head;
    tail_nxt  = cur_tail;
    empty_nxt = cur_empty;
    case (in_item.op)
      mlqb_pkg::OP_ENQ: begin
        if (!q_ok) begin
          status = mlqb_pkg::ST_FULL;
        end else if (cur_empty) begin
          wen       = 1'b1;
          ptr_wen   = 1'b1;
          head_nxt  = '0;
          tail_nxt  = '0;
          empty_nxt = 1'b0;
        end else if (cur_tail == PW'(QUEUE_DEPTH - 1)) begin
          status = mlqb_pkg::ST_FULL;
        end else begin
          wen      = 1'b1;
          ptr_wen  = 1'b1;
          tail_nxt = cur_tail + 1'b1;
          waddr    = base + AW'(tail_nxt);
        end
      end
      mlqb_pkg::OP_DEQ, mlqb_pkg::OP_PEEK: begin
        if (!q_ok || cur_empty) begin
          status = mlqb_pkg::ST_EMPTY;
        end else begin
          hit = 1'b1;
          if (in_item.op == mlqb_pkg::OP_DEQ) begin
            ptr_wen = 1'b1;
            if (cur_head == cur_tail) begin
              head_nxt  = '0;
              tail_nxt  = '0;
              empty_nxt = 1'b1;
            end else begin
              head_nxt = cur_head + 1'b1;
            end
          end
        end
      end
      default: begin
        status = mlqb_pkg::ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_r <= '1;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
    end else if (accept && ptr_wen) begin
      head_r[q]  <= head_nxt;
      tail_r[q]  <= tail_nxt;
      empty_r[q] <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wen) begin
      mem[waddr] <= DATA_WIDTH'(in_item.value);
    end
    if (accept) begin
      rd_r <= mem[raddr];
    end
  end

  assign out_free         = !out_valid_r || !out_stall;
  assign s1_move          = s1_valid_r && !sk_valid_r;
  assign s1_item.word_out = s1_hit_r ? mlqb_pkg::FIELD_W'(rd_r) : '0;
  assign s1_item.status   = s1_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r  <= 1'b1;
        s1_hit_r    <= hit;
        s1_status_r <= status;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (out_free) begin
        if (sk_valid_r) begin
          out_valid_r <= 1'b1;
          out_item_r  <= sk_item_r;
          sk_valid_r  <= 1'b0;
        end else if (s1_valid_r) begin
          out_valid_r <= 1'b1;
          out_item_r  <= s1_item;
        end else begin
          out_valid_r <= 1'b0;
        end
      end else if (s1_move) begin
        sk_valid_r <= 1'b1;
        sk_item_r  <= s1_item;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* rtl/core/mlqb_checker.sv */
// Checker: port-level assertions for the multi-linear queue buffer, with its bind.
module mlqb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input mlqb_pkg::out_item_t out_item
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("out_valid or in_stall set after reset");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != mlqb_pkg::ST_DONE |-> out_item.word_out == '0)
    else $error("refused request returned a non-zero word");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_beat_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_item))
    else $error("stalled result beat changed");

endmodule

bind multi_linear_queue_buffer_top mlqb_checker u_mlqb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
